FILE: src/lzw_compressor_defines.svh
// Assertion macros for the LZW compressor.
`ifndef LZW_COMPRESSOR_DEFINES_SVH
`define LZW_COMPRESSOR_DEFINES_SVH

// Condition in this cycle implies consequence in the same cycle.
`define LZWC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define LZWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants and controller/datapath interface types for the LZW block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzwc_pkg;

    localparam int DictEntriesDef  = 4096;
    localparam int AlphabetSizeDef = 64;
    localparam int SymbolW         = 6;
    localparam int CodeOutW        = 12;
    localparam int SymbolTabDepth  = 1 << SymbolW;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the input word
        logic rd_child;  // read child table at {current code, symbol}
        logic rd_entry;  // read dictionary entry at the child candidate
        logic update;    // apply hit/miss, emit on miss
        logic flush;     // emit current code as last, end the stream
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_busy; // child table clear after reset still running
        logic miss;      // active string and no match
        logic is_last;   // captured word closes the stream
        logic out_free;  // output register can take a word this cycle
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/lzw_compressor.sv
// ----------------------------------------------------------------------------
// lzw_compressor
// LZW encoder: symbols in on the slave stream, dictionary codes out.
//
// s_tdata[5:0] carries a symbol, s_tlast marks the last symbol of a stream.
// m_tdata[11:0] carries a code, m_tlast marks the final code of a stream.
// One word is in work at a time, through accept, child table read,
// dictionary entry read and decide; a closing word adds a flush step for
// the flush code. The lookup costs two dependent memory reads: a table
// indexed by {prefix code, symbol} names a candidate code, and the
// dictionary entry of that candidate confirms it, so stale table words left
// by earlier streams do no harm.
// The decide step registers a miss code, the flush step the flush code.
// Reset empties the dictionary and starts a fresh stream; a stream end does
// the same. After reset the child table is cleared once, one word a cycle,
// all 1 << (CodeW + SymW) words (262144 at the defaults), with s_tready
// low. A stalled receiver holds the output register; the flush step waits
// for it, the decide step only on a miss, and s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_compressor_defines.svh"

module lzw_compressor #(
    parameter int DICT_ENTRIES  = lzwc_pkg::DictEntriesDef,
    parameter int ALPHABET_SIZE = lzwc_pkg::AlphabetSizeDef
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [5:0] symbol, [7:6] zero
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [11:0] code, [15:12] zero
    output logic             m_tlast
);
    import lzwc_pkg::*;

    ctl_cmd_t            cmd;
    dp_status_t          status;
    logic [CodeOutW-1:0] code;

    lzwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzwc_datapath #(
        .DICT_ENTRIES  (DICT_ENTRIES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_symbol (s_tdata[SymbolW-1:0]),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_code  (code),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0, code};

    `LZWC_ASSERT_NEXT(a_one_word_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")
    `LZWC_ASSERT_NEXT(a_hold_while_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
    `LZWC_ASSERT_SAME(a_single_step, aclk, aresetn, cmd.update || cmd.flush, !(cmd.update && cmd.flush) && !s_tready, "update and flush overlap")

endmodule

`default_nettype wire

FILE: src/lzwc_ctrl.sv
// ----------------------------------------------------------------------------
// lzwc_ctrl
// Sequencer: accept, child read, entry read, decide, optional flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzwc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lzwc_pkg::dp_status_t  status,
    output lzwc_pkg::ctl_cmd_t         cmd
);
    import lzwc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CHILD,
        S_RD_ENTRY,
        S_DECIDE,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // hold off input until the child table is cleared
                in_ready = !status.init_busy;
                if (in_valid && !status.init_busy) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RD_CHILD;
                end
            end
            S_RD_CHILD: begin
                cmd.rd_child = 1'b1;
                state_next   = S_RD_ENTRY;
            end
            S_RD_ENTRY: begin
                cmd.rd_entry = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE: begin
                // hold while a miss code has nowhere to go
                if (!status.miss || status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = status.is_last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/lzwc_datapath.sv
// ----------------------------------------------------------------------------
// lzwc_datapath
// String state, child index table, dictionary entries and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzwc_datapath #(
    parameter int DICT_ENTRIES  = lzwc_pkg::DictEntriesDef,
    parameter int ALPHABET_SIZE = lzwc_pkg::AlphabetSizeDef
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [lzwc_pkg::SymbolW-1:0]  in_symbol,
    input  wire logic                          in_last,
    input  wire lzwc_pkg::ctl_cmd_t            cmd,
    output lzwc_pkg::dp_status_t               status,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [lzwc_pkg::CodeOutW-1:0]      out_code,
    output logic                               out_last
);
    import lzwc_pkg::*;

    localparam int CodeW     = $clog2(DICT_ENTRIES);
    localparam int SymW      = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ChildAw   = CodeW + SymW;
    localparam int ChildDepth = 1 << ChildAw;

    // symbol reduced modulo the alphabet, one entry per raw symbol
    logic [SymW-1:0] sym_tab [SymbolTabDepth];
    for (genvar g = 0; g < SymbolTabDepth; g++) begin : g_symtab
        assign sym_tab[g] = SymW'(g % ALPHABET_SIZE);
    end

    logic [SymW-1:0]  sym_reg;
    logic             last_reg;
    logic [CodeW-1:0] cur_reg;
    logic             active_reg;
    logic [CodeW:0]   free_reg;
    logic [CodeW-1:0] child_q_reg;
    logic [CodeW-1:0] ent_pre_q_reg;
    logic [SymW-1:0]  ent_sym_q_reg;
    logic             out_valid_reg;
    logic [CodeOutW-1:0] out_code_reg;
    logic             out_last_reg;
    logic [ChildAw-1:0] clr_addr_reg;
    logic             clr_busy_reg;

    // child table: {prefix, symbol} -> last code added for it; verified below
    logic [CodeW-1:0] child_mem [ChildDepth];
    logic [CodeW-1:0] pre_mem   [DICT_ENTRIES];
    logic [SymW-1:0]  sym_mem   [DICT_ENTRIES];

    logic             hit;
    logic             room;
    logic [CodeW-1:0] sym_code;
    logic [CodeW+CodeOutW-1:0] cur_ext;
    logic [CodeW+CodeOutW-1:0] emit_ext;
    logic             out_free;

    assign hit = ({1'b0, child_q_reg} >= (CodeW+1)'(ALPHABET_SIZE))
              && ({1'b0, child_q_reg} < free_reg)
              && (ent_pre_q_reg == cur_reg)
              && (ent_sym_q_reg == sym_reg);
    assign room     = free_reg < (CodeW+1)'(DICT_ENTRIES);
    assign sym_code = {{(CodeW-SymW){1'b0}}, sym_reg};
    assign cur_ext  = {{CodeOutW{1'b0}}, cur_reg};
    assign out_free = !out_valid_reg || out_ready;

    assign status.init_busy = clr_busy_reg;
    assign status.miss      = active_reg && !hit;
    assign status.is_last   = last_reg;
    assign status.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;

    // code after the decide step, used by the flush
    assign emit_ext = cur_ext;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sym_reg  <= sym_tab[in_symbol];
            last_reg <= in_last;
        end
        if (cmd.rd_child) begin
            child_q_reg <= child_mem[{cur_reg, sym_reg}];
        end
        if (cmd.rd_entry) begin
            ent_pre_q_reg <= pre_mem[child_q_reg];
            ent_sym_q_reg <= sym_mem[child_q_reg];
        end
        if (clr_busy_reg) begin
            // zero points below the alphabet, so a cleared word never hits
            child_mem[clr_addr_reg] <= '0;
        end else if (cmd.update && active_reg && !hit && room) begin
            child_mem[{cur_reg, sym_reg}] <= free_reg[CodeW-1:0];
            pre_mem[free_reg[CodeW-1:0]]  <= cur_reg;
            sym_mem[free_reg[CodeW-1:0]]  <= sym_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            active_reg    <= 1'b0;
            free_reg      <= (CodeW+1)'(ALPHABET_SIZE);
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_busy_reg  <= 1'b1;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.update) begin
                if (!active_reg) begin
                    cur_reg    <= sym_code;
                    active_reg <= 1'b1;
                end else if (hit) begin
                    cur_reg <= child_q_reg;
                end else begin
                    cur_reg <= sym_code;
                    if (room) begin
                        free_reg <= free_reg + 1'b1;
                    end
                    out_valid_reg <= 1'b1;
                    out_code_reg  <= cur_ext[CodeOutW-1:0];
                    out_last_reg  <= 1'b0;
                end
            end
            if (cmd.flush) begin
                out_valid_reg <= 1'b1;
                out_code_reg  <= emit_ext[CodeOutW-1:0];
                out_last_reg  <= 1'b1;
                cur_reg       <= '0;
                active_reg    <= 1'b0;
                free_reg      <= (CodeW+1)'(ALPHABET_SIZE);
            end
        end
    end

endmodule

`default_nettype wire
